/* rtl/core/gwsd_pkg.sv */
package gwsd_pkg;

  // field and state widths
  localparam int RATE_WIDTH_DEF = 22;
  localparam int MAG_W          = 22;
  localparam int LEN_W          = 10;
  localparam int SUM_W          = 32;
  localparam int SQS_W          = 54;
  localparam int NN_W           = 2 * LEN_W;
  localparam int WIDE_W         = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 22;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STD_LIMIT     = 2'd3;

  // register reset values
  localparam logic [LEN_W-1:0] RST_WINDOW_LENGTH = 10'd300;
  localparam logic [MAG_W-1:0] RST_MAX_LIMIT     = 22'd247406;
  localparam logic [MAG_W-1:0] RST_MIN_LIMIT     = 22'd4590;
  localparam logic [MAG_W-1:0] RST_STD_LIMIT     = 22'd63222;

  // snapshot of one closed window
  typedef struct packed {
    logic [LEN_W-1:0] n;
    logic [MAG_W-1:0] max;
    logic [MAG_W-1:0] min;
    logic [SUM_W-1:0] sum;
    logic [SQS_W-1:0] sqs;
  } win_t;

endpackage

/* rtl/core/gwsd_in_if.sv */
interface gwsd_in_if #(
  parameter int RATE_WIDTH = gwsd_pkg::RATE_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [RATE_WIDTH-1:0] rate_x;
  logic signed [RATE_WIDTH-1:0] rate_y;
  logic signed [RATE_WIDTH-1:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

/* rtl/core/gwsd_out_if.sv */
interface gwsd_out_if ();
  logic                           valid;
  logic                           ready;
  logic                           attack_flag;
  logic [gwsd_pkg::MAG_W-1:0]     window_max;
  logic [gwsd_pkg::MAG_W-1:0]     window_min;
  logic [gwsd_pkg::MAG_W-1:0]     window_std;

  modport source (output valid, output attack_flag, output window_max, output window_min,
                  output window_std, input ready);
  modport sink   (input valid, input attack_flag, input window_max, input window_min,
                  input window_std, output ready);
endinterface

/* rtl/core/gwsd_front.sv */
module gwsd_front #(
  parameter int RATE_WIDTH = gwsd_pkg::RATE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gwsd_in_if.sink                    in_ch,
  input  logic [gwsd_pkg::LEN_W-1:0] window_length,
  input  logic                       q_full,
  output logic                       push,
  output gwsd_pkg::win_t             push_data
);

  localparam int SQ_W   = 2 * RATE_WIDTH;
  localparam int STEP_W = $clog2(RATE_WIDTH);

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_ROOT, F_COMMIT} fstate_t;

  fstate_t                        state_r;
  logic [RATE_WIDTH-1:0]          abs_r [3];
  logic [1:0]                     axis_r;
  logic [STEP_W-1:0]              step_r;
  logic [SQ_W-1:0]                acc_r;
  logic [SQ_W-1:0]                root_r;
  logic [SQ_W-1:0]                bit_r;
  logic [gwsd_pkg::LEN_W-1:0]     count_r;
  logic [gwsd_pkg::MAG_W-1:0]     max_r;
  logic [gwsd_pkg::MAG_W-1:0]     min_r;
  logic [gwsd_pkg::SUM_W-1:0]     sum_r;
  logic [gwsd_pkg::SQS_W-1:0]     sqs_r;

  logic [SQ_W-1:0]                trial;
  logic [gwsd_pkg::MAG_W-1:0]     mag;
  logic [gwsd_pkg::LEN_W-1:0]     len_eff;
  logic                           eval;
  logic [gwsd_pkg::LEN_W-1:0]     b_count;
  logic [gwsd_pkg::MAG_W-1:0]     b_max;
  logic [gwsd_pkg::MAG_W-1:0]     b_min;
  logic [gwsd_pkg::SUM_W-1:0]     b_sum;
  logic [gwsd_pkg::SQS_W-1:0]     b_sqs;
  logic [2*gwsd_pkg::MAG_W-1:0]   mag_sq;

  function automatic logic [RATE_WIDTH-1:0] abs_val(input logic signed [RATE_WIDTH-1:0] v);
    abs_val = v[RATE_WIDTH-1] ? RATE_WIDTH'(-v) : RATE_WIDTH'(v);
  endfunction

  assign in_ch.ready = (state_r == F_IDLE);

  // root step and saturated magnitude
  assign trial   = root_r + bit_r;
  assign mag     = (root_r > SQ_W'(gwsd_pkg::MAG_MAX)) ? gwsd_pkg::MAG_MAX
                                                       : root_r[gwsd_pkg::MAG_W-1:0];
  assign mag_sq  = (2*gwsd_pkg::MAG_W)'(mag) * (2*gwsd_pkg::MAG_W)'(mag);

  // window close decision
  assign len_eff = (window_length < gwsd_pkg::LEN_MIN) ? gwsd_pkg::LEN_MIN : window_length;
  assign eval    = (count_r >= len_eff);
  assign push    = (state_r == F_COMMIT) && eval && !q_full;

  assign push_data.n   = count_r;
  assign push_data.max = max_r;
  assign push_data.min = min_r;
  assign push_data.sum = sum_r;
  assign push_data.sqs = sqs_r;

  // accumulators after an optional clear
  assign b_count = eval ? '0 : count_r;
  assign b_max   = eval ? '0 : max_r;
  assign b_min   = eval ? gwsd_pkg::MAG_MAX : min_r;
  assign b_sum   = eval ? '0 : sum_r;
  assign b_sqs   = eval ? '0 : sqs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      count_r <= '0;
      max_r   <= '0;
      min_r   <= gwsd_pkg::MAG_MAX;
      sum_r   <= '0;
      sqs_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            abs_r[0] <= abs_val(in_ch.rate_x);
            abs_r[1] <= abs_val(in_ch.rate_y);
            abs_r[2] <= abs_val(in_ch.rate_z);
            acc_r    <= '0;
            axis_r   <= '0;
            state_r  <= F_SQ;
          end
        end
        F_SQ: begin
          // one square per cycle, axes shift down
          acc_r    <= acc_r + SQ_W'(abs_r[0]) * SQ_W'(abs_r[0]);
          abs_r[0] <= abs_r[1];
          abs_r[1] <= abs_r[2];
          axis_r   <= axis_r + 2'd1;
          if (axis_r == 2'd2) begin
            root_r  <= '0;
            bit_r   <= SQ_W'(1) << (SQ_W - 2);
            step_r  <= '0;
            state_r <= F_ROOT;
          end
        end
        F_ROOT: begin
          if (acc_r >= trial) begin
            acc_r  <= acc_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(RATE_WIDTH - 1)) begin
            state_r <= F_COMMIT;
          end
        end
        F_COMMIT: begin
          if (!eval || !q_full) begin
            count_r <= b_count + 1'b1;
            max_r   <= (mag > b_max) ? mag : b_max;
            min_r   <= (mag < b_min) ? mag : b_min;
            sum_r   <= b_sum + gwsd_pkg::SUM_W'(mag);
            sqs_r   <= b_sqs + gwsd_pkg::SQS_W'(mag_sq);
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/gwsd_queue.sv */
module gwsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gwsd_pkg::win_t push_data,
  input  logic           pop,
  output gwsd_pkg::win_t pop_data,
  output logic           full,
  output logic           empty
);

  gwsd_pkg::win_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // two-entry window queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/core/gwsd_back.sv */
module gwsd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  gwsd_pkg::win_t             pop_data,
  output logic                       pop,
  input  logic [gwsd_pkg::MAG_W-1:0] max_limit,
  input  logic [gwsd_pkg::MAG_W-1:0] min_limit,
  input  logic [gwsd_pkg::MAG_W-1:0] std_limit,
  gwsd_out_if.source                 out_ch
);

  localparam int W = gwsd_pkg::WIDE_W;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUB, B_DIV, B_ROOT, B_DONE} bstate_t;

  bstate_t                        state_r;
  logic [5:0]                     step_r;
  logic [gwsd_pkg::LEN_W-1:0]     n_r;
  logic [gwsd_pkg::MAG_W-1:0]     max_r;
  logic [gwsd_pkg::MAG_W-1:0]     min_r;
  logic [gwsd_pkg::SQS_W-1:0]     sqs_r;
  logic [gwsd_pkg::NN_W-1:0]      nn_r;
  logic [W-1:0]                   a_r;
  logic [W-1:0]                   b_r;
  logic [W-1:0]                   quo_r;
  logic [gwsd_pkg::NN_W-1:0]      rem_r;
  logic [W-1:0]                   root_r;
  logic [W-1:0]                   bit_r;
  logic                           out_valid_r;
  logic                           flag_r;
  logic [gwsd_pkg::MAG_W-1:0]     omax_r;
  logic [gwsd_pkg::MAG_W-1:0]     omin_r;
  logic [gwsd_pkg::MAG_W-1:0]     ostd_r;

  logic [gwsd_pkg::NN_W:0]        div_trial;
  logic                           div_ge;
  logic [W-1:0]                   rt_trial;
  logic [gwsd_pkg::MAG_W-1:0]     sd;
  logic                           load_out;

  assign pop = (state_r == B_IDLE) && !q_empty;

  // restoring divide step
  assign div_trial = {rem_r, quo_r[W-1]};
  assign div_ge    = (div_trial >= {1'b0, nn_r});

  // square root step and saturation
  assign rt_trial = root_r + bit_r;
  assign sd       = (root_r > W'(gwsd_pkg::MAG_MAX)) ? gwsd_pkg::MAG_MAX
                                                      : root_r[gwsd_pkg::MAG_W-1:0];
  assign load_out = (state_r == B_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.attack_flag = flag_r;
  assign out_ch.window_max  = omax_r;
  assign out_ch.window_min  = omin_r;
  assign out_ch.window_std  = ostd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output beat: load a new result or drop the accepted one
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            n_r     <= pop_data.n;
            max_r   <= pop_data.max;
            min_r   <= pop_data.min;
            sqs_r   <= pop_data.sqs;
            b_r     <= W'(pop_data.sum) * W'(pop_data.sum);
            nn_r    <= gwsd_pkg::NN_W'(pop_data.n) * gwsd_pkg::NN_W'(pop_data.n);
            a_r     <= '0;
            step_r  <= '0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          // n * sum of squares, shift and add over count bits
          if (n_r[step_r[3:0]]) begin
            a_r <= a_r + (W'(sqs_r) << step_r[3:0]);
          end
          step_r <= step_r + 1'b1;
          if (step_r == 6'(gwsd_pkg::LEN_W - 1)) begin
            state_r <= B_SUB;
          end
        end
        B_SUB: begin
          quo_r   <= (a_r > b_r) ? a_r - b_r : '0;
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          rem_r  <= div_ge ? gwsd_pkg::NN_W'(div_trial - {1'b0, nn_r})
                           : div_trial[gwsd_pkg::NN_W-1:0];
          quo_r  <= {quo_r[W-2:0], div_ge};
          if (step_r == 6'(W - 1)) begin
            root_r  <= '0;
            bit_r   <= W'(1) << (W - 2);
            step_r  <= '0;
            state_r <= B_ROOT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        B_ROOT: begin
          if (quo_r >= rt_trial) begin
            quo_r  <= quo_r - rt_trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          step_r <= step_r + 1'b1;
          if (step_r == 6'(W / 2 - 1)) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (load_out) begin
            flag_r      <= (max_r < max_limit) && (min_r >= min_limit) && (sd < std_limit);
            omax_r      <= max_r;
            omin_r      <= min_r;
            ostd_r      <= sd;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/gyro_window_spoof_detector.sv */
// Channel  Dir  Beat
// in_ch    in   rate_x, rate_y, rate_z (signed, RATE_WIDTH bits)
// out_ch   out  attack_flag, window_max, window_min, window_std
// cfg_*    in   write enable, register index, 22-bit data
//
// In the front a sample passes through three squaring steps, one square-root
// step per cycle, then the accumulate step, which may wait on a full queue.
// A closed window passes through the back in 10 shift-add steps, a 64-step
// divider and a 32-step square root; the back pops the next one when idle.
// Synchronous active-low reset clears accumulators, queue and handshakes.
// A two-entry window queue lets the front keep taking samples while the
// back works or the output beat stalls, until the queue is full.
module gyro_window_spoof_detector #(
  parameter int RATE_WIDTH = gwsd_pkg::RATE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gwsd_in_if.sink                         in_ch,
  gwsd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [gwsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gwsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [gwsd_pkg::LEN_W-1:0] window_length_r;
  logic [gwsd_pkg::MAG_W-1:0] max_limit_r;
  logic [gwsd_pkg::MAG_W-1:0] min_limit_r;
  logic [gwsd_pkg::MAG_W-1:0] std_limit_r;

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  gwsd_pkg::win_t push_data;
  gwsd_pkg::win_t pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= gwsd_pkg::RST_WINDOW_LENGTH;
      max_limit_r     <= gwsd_pkg::RST_MAX_LIMIT;
      min_limit_r     <= gwsd_pkg::RST_MIN_LIMIT;
      std_limit_r     <= gwsd_pkg::RST_STD_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        gwsd_pkg::REG_WINDOW_LENGTH: window_length_r <= cfg_data[gwsd_pkg::LEN_W-1:0];
        gwsd_pkg::REG_MAX_LIMIT:     max_limit_r     <= cfg_data[gwsd_pkg::MAG_W-1:0];
        gwsd_pkg::REG_MIN_LIMIT:     min_limit_r     <= cfg_data[gwsd_pkg::MAG_W-1:0];
        gwsd_pkg::REG_STD_LIMIT:     std_limit_r     <= cfg_data[gwsd_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  gwsd_front #(.RATE_WIDTH(RATE_WIDTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .window_length (window_length_r),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  gwsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  gwsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .max_limit (max_limit_r),
    .min_limit (min_limit_r),
    .std_limit (std_limit_r),
    .out_ch    (out_ch)
  );

endmodule
